// ===== design/kvsg_pkg.sv =====
// Shared types and constants for the keyed value stream generator.
// Used by kvsg_ctrl, kvsg_dp and keyed_value_stream_generator; no dependencies.
package kvsg_pkg;

    localparam int unsigned SIZE_W     = 21;
    localparam int unsigned SEED_BYTES = 8;
    localparam int unsigned CFG_IDX_W  = 2;

    localparam logic [32:0] MAX_VALUE_BYTES_DEF = 33'd1048576;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_SEED       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_SIZE = 2'd1;

    // Request codes.
    localparam logic REQ_KEY = 1'b0;
    localparam logic REQ_GEN = 1'b1;

    localparam logic [63:0] FNV_BASIS  = 64'hCBF29CE484222325;
    localparam logic [8:0]  FNV_PRIME_LO = 9'h1B3;
    localparam int unsigned FNV_PRIME_SHIFT = 40;
    localparam logic [63:0] MIX_INC  = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_MUL1 = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_MUL2 = 64'h94D049BB133111EB;

    typedef struct packed {
        logic       load_item;
        logic       seed_fold;
        logic [2:0] seed_idx;
        logic       key_fold;
        logic       gen_start;
        logic       mul_lo_lo;
        logic       mul_lo_hi;
        logic       mul_hi_lo;
        logic       mul_second;
        logic       mix_xs;
        logic       emit;
    } cmd_t;

    typedef struct packed {
        logic bytes_zero;
        logic out_free;
    } status_t;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_SEED   = 9'b000000010,
        ST_KEY    = 9'b000000100,
        ST_MUL_LL = 9'b000001000,
        ST_MUL_LH = 9'b000010000,
        ST_MUL_HL = 9'b000100000,
        ST_MIX_XS = 9'b001000000,
        ST_EMIT   = 9'b010000000,
        ST_SPARE  = 9'b100000000
    } state_t;

    // FNV-1a step: xor the byte, multiply by 2^40 + 0x1B3 modulo 2^64.
    function automatic logic [63:0] fnv_fold(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] t;
        logic [63:0] small_prod;
        begin
            t = h ^ {56'd0, b};
            small_prod = t * {55'd0, FNV_PRIME_LO};
            fnv_fold = small_prod + (t << FNV_PRIME_SHIFT);
        end
    endfunction

endpackage

// ===== design/kvsg_ctrl.sv =====
// Controller state machine for the keyed value stream generator.
// Depends on kvsg_pkg; drives the command struct into kvsg_dp.
module kvsg_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_type,
    input  logic              key_first,
    output logic              req_stall,
    input  kvsg_pkg::status_t status,
    output kvsg_pkg::cmd_t    cmd
);

    kvsg_pkg::state_t state_reg;
    kvsg_pkg::state_t state_next;
    logic [2:0]       idx_reg;
    logic [2:0]       idx_next;
    logic             second_reg;
    logic             second_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= kvsg_pkg::ST_IDLE;
            idx_reg    <= '0;
            second_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            second_reg <= second_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        second_next    = second_reg;
        cmd            = '0;
        cmd.mul_second = second_reg;
        cmd.seed_idx   = idx_reg;
        req_stall      = 1'b1;
        case (state_reg)
            kvsg_pkg::ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.load_item = 1'b1;
                    if (req_type == kvsg_pkg::REQ_KEY)
                    begin
                        if (key_first)
                        begin
                            idx_next   = '0;
                            state_next = kvsg_pkg::ST_SEED;
                        end
                        else
                        begin
                            state_next = kvsg_pkg::ST_KEY;
                        end
                    end
                    else if (!status.bytes_zero)
                    begin
                        // A request with the budget spent is simply dropped.
                        cmd.gen_start = 1'b1;
                        second_next   = 1'b0;
                        state_next    = kvsg_pkg::ST_MUL_LL;
                    end
                end
            end
            kvsg_pkg::ST_SEED:
            begin
                cmd.seed_fold = 1'b1;
                idx_next      = idx_reg + 3'd1;
                if (idx_reg == 3'(kvsg_pkg::SEED_BYTES - 1))
                begin
                    state_next = kvsg_pkg::ST_KEY;
                end
            end
            kvsg_pkg::ST_KEY:
            begin
                cmd.key_fold = 1'b1;
                state_next   = kvsg_pkg::ST_IDLE;
            end
            kvsg_pkg::ST_MUL_LL:
            begin
                cmd.mul_lo_lo = 1'b1;
                state_next    = kvsg_pkg::ST_MUL_LH;
            end
            kvsg_pkg::ST_MUL_LH:
            begin
                cmd.mul_lo_hi = 1'b1;
                state_next    = kvsg_pkg::ST_MUL_HL;
            end
            kvsg_pkg::ST_MUL_HL:
            begin
                cmd.mul_hi_lo = 1'b1;
                state_next    = second_reg ? kvsg_pkg::ST_EMIT : kvsg_pkg::ST_MIX_XS;
            end
            kvsg_pkg::ST_MIX_XS:
            begin
                cmd.mix_xs  = 1'b1;
                second_next = 1'b1;
                state_next  = kvsg_pkg::ST_MUL_LL;
            end
            kvsg_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = kvsg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kvsg_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/kvsg_dp.sv =====
// Datapath: configuration registers, FNV-1a hash, SplitMix64 state with a
// shared 32x32 multiplier, byte budget and the output word register.
// Depends on kvsg_pkg; controlled by kvsg_ctrl.
module kvsg_dp
#(
    parameter logic [32:0] MAX_VALUE_BYTES = kvsg_pkg::MAX_VALUE_BYTES_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic [kvsg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [63:0]                      cfg_data,
    input  logic [7:0]                       key_byte,
    input  logic                             key_last,
    input  kvsg_pkg::cmd_t                   cmd,
    output kvsg_pkg::status_t                status,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output logic [63:0]                      value_word,
    output logic [3:0]                       byte_count,
    output logic                             last_word
);

    localparam int unsigned SW = kvsg_pkg::SIZE_W;

    logic [63:0]   seed_reg;
    logic [SW-1:0] value_size_reg;
    logic [63:0]   hash_reg;
    logic [63:0]   mix_reg;
    logic [SW-1:0] left_reg;
    logic [7:0]    key_byte_reg;
    logic          key_last_reg;
    logic [63:0]   x_reg;
    logic [63:0]   acc_reg;
    logic [3:0]    cnt_reg;
    logic          last_reg;
    logic          out_valid_reg;
    logic [63:0]   out_word_reg;
    logic [3:0]    out_cnt_reg;
    logic          out_last_reg;

    logic [63:0]   seed_fold_val;
    logic [63:0]   key_fold_val;
    logic [63:0]   mix_inc_val;
    logic [3:0]    gen_cnt;
    logic [SW-1:0] left_next;
    logic [SW-1:0] capped_size;
    logic [63:0]   mul_const;
    logic [31:0]   mul_a;
    logic [31:0]   mul_b;
    logic [63:0]   mul_prod;

    assign seed_fold_val = kvsg_pkg::fnv_fold(
        (cmd.seed_idx == 3'd0) ? kvsg_pkg::FNV_BASIS : hash_reg,
        seed_reg[{cmd.seed_idx, 3'b000} +: 8]);
    assign key_fold_val  = kvsg_pkg::fnv_fold(hash_reg, key_byte_reg);
    assign mix_inc_val   = mix_reg + kvsg_pkg::MIX_INC;

    assign gen_cnt     = (left_reg > SW'(8)) ? 4'd8 : left_reg[3:0];
    assign left_next   = left_reg - SW'(gen_cnt);
    assign capped_size = ({12'd0, value_size_reg} > MAX_VALUE_BYTES)
                         ? MAX_VALUE_BYTES[SW-1:0] : value_size_reg;

    // The low 64 bits of a 64x64 product come from three 32x32 partial products.
    assign mul_const = cmd.mul_second ? kvsg_pkg::MIX_MUL2 : kvsg_pkg::MIX_MUL1;
    assign mul_a     = cmd.mul_hi_lo ? x_reg[63:32] : x_reg[31:0];
    assign mul_b     = cmd.mul_lo_hi ? mul_const[63:32] : mul_const[31:0];
    assign mul_prod  = mul_a * mul_b;

    assign status.bytes_zero = (left_reg == '0);
    assign status.out_free   = !out_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg       <= '0;
            value_size_reg <= '0;
            hash_reg       <= '0;
            mix_reg        <= '0;
            left_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == kvsg_pkg::REG_SEED)
                begin
                    seed_reg <= cfg_data;
                end
                else if (cfg_index == kvsg_pkg::REG_VALUE_SIZE)
                begin
                    value_size_reg <= cfg_data[SW-1:0];
                end
            end
            if (cmd.seed_fold)
            begin
                hash_reg <= seed_fold_val;
            end
            if (cmd.key_fold)
            begin
                hash_reg <= key_fold_val;
                if (key_last_reg)
                begin
                    mix_reg  <= key_fold_val;
                    left_reg <= capped_size;
                end
            end
            if (cmd.gen_start)
            begin
                mix_reg  <= mix_inc_val;
                left_reg <= left_next;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            key_byte_reg <= key_byte;
            key_last_reg <= key_last;
        end
        if (cmd.gen_start)
        begin
            x_reg    <= mix_inc_val ^ (mix_inc_val >> 30);
            cnt_reg  <= gen_cnt;
            last_reg <= (left_next == '0);
        end
        if (cmd.mix_xs)
        begin
            x_reg <= acc_reg ^ (acc_reg >> 27);
        end
        if (cmd.mul_lo_lo)
        begin
            acc_reg <= mul_prod;
        end
        if (cmd.mul_lo_hi || cmd.mul_hi_lo)
        begin
            acc_reg <= {acc_reg[63:32] + mul_prod[31:0], acc_reg[31:0]};
        end
        if (cmd.emit)
        begin
            out_word_reg <= acc_reg ^ (acc_reg >> 31);
            out_cnt_reg  <= cnt_reg;
            out_last_reg <= last_reg;
        end
    end

    assign rsp_valid  = out_valid_reg;
    assign value_word = out_word_reg;
    assign byte_count = out_cnt_reg;
    assign last_word  = out_last_reg;

endmodule

// ===== design/keyed_value_stream_generator.sv =====
// Top level of the keyed value stream generator: FNV-1a key hash seeding a
// SplitMix64 word stream. Depends on kvsg_pkg, kvsg_ctrl and kvsg_dp.
//
//   Channel   Handshake              Payload
//   cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//   req       req_valid / req_stall  req_type, key_byte, key_first, key_last
//   rsp       rsp_valid / rsp_stall  value_word, byte_count, last_word
//
// A key byte is folded in the KEY state, after the SEED state when it starts a key
// (eight seed bytes are folded first, one per cycle). A generate request makes two
// 64-bit multiplies, each three passes through the single 32x32 multiplier. A
// request with the byte budget spent is taken but gives no word. Reset clears the
// control and config state, not all data registers; cfg_ready is always high. The
// result word sits in an output register, so a new request is taken while it waits on rsp_stall.
module keyed_value_stream_generator
#(
    parameter logic [32:0] MAX_VALUE_BYTES = kvsg_pkg::MAX_VALUE_BYTES_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [kvsg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                    cfg_data,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  logic                           req_type,
    input  logic [7:0]                     key_byte,
    input  logic                           key_first,
    input  logic                           key_last,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output logic [63:0]                    value_word,
    output logic [3:0]                     byte_count,
    output logic                           last_word
);

    kvsg_pkg::cmd_t    cmd;
    kvsg_pkg::status_t status;

    assign cfg_ready = 1'b1;

    kvsg_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_type  (req_type),
        .key_first (key_first),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    kvsg_dp
    #(
        .MAX_VALUE_BYTES (MAX_VALUE_BYTES)
    )
    u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .key_byte   (key_byte),
        .key_last   (key_last),
        .cmd        (cmd),
        .status     (status),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .value_word (value_word),
        .byte_count (byte_count),
        .last_word  (last_word)
    );

endmodule
